>>> rtl/core/bclm_pkg.sv
// ----------------------------------------------------------------------------
// bclm_pkg
// Shared types, codes and constants of the bicolour LED matrix frame store.
// ----------------------------------------------------------------------------
package bclm_pkg;

  localparam int ROWS_DEF = 16;
  localparam int PLANE_W  = 16;
  localparam int ADDR_W   = 4;

  localparam logic [PLANE_W-1:0] TOP_BIT = 16'h8000;

  typedef logic [1:0]         mode_t;
  typedef logic [1:0]         color_t;
  typedef logic [ADDR_W-1:0]  row_t;
  typedef logic [3:0]         bit_t;
  typedef logic [PLANE_W-1:0] plane_t;

  localparam mode_t MODE_PLOT  = 2'd0;
  localparam mode_t MODE_CLEAR = 2'd1;
  localparam mode_t MODE_SCAN  = 2'd2;
  localparam mode_t MODE_BLANK = 2'd3;

  localparam color_t COLOR_OFF    = 2'd0;
  localparam color_t COLOR_GREEN  = 2'd1;
  localparam color_t COLOR_RED    = 2'd2;
  localparam color_t COLOR_YELLOW = 2'd3;

  // Request from the sequencer to the frame store.
  typedef struct packed {
    logic   rd_en;
    row_t   rd_addr;
    logic   wr_en;
    row_t   wr_addr;
    plane_t wr_green;
    plane_t wr_red;
    logic   clr;
  } store_req_t;

  // Registered read data of both planes.
  typedef struct packed {
    plane_t green;
    plane_t red;
  } store_rd_t;

endpackage

>>> rtl/core/bclm_if.sv
// ----------------------------------------------------------------------------
// bclm_in_if / bclm_out_if
// Valid/ready channels carrying command beats in and latch words out.
// ----------------------------------------------------------------------------
interface bclm_in_if;
  import bclm_pkg::*;

  logic   valid;
  logic   ready;
  mode_t  mode;
  color_t color;
  row_t   pixel_row;
  bit_t   pixel_bit;

  modport source (output valid, output mode, output color, output pixel_row,
                  output pixel_bit, input ready);
  modport sink   (input valid, input mode, input color, input pixel_row,
                  input pixel_bit, output ready);
endinterface

interface bclm_out_if;
  import bclm_pkg::*;

  logic   valid;
  logic   ready;
  plane_t red_cathode;
  plane_t green_cathode;
  plane_t anode;
  row_t   scan_row;

  modport source (output valid, output red_cathode, output green_cathode,
                  output anode, output scan_row, input ready);
  modport sink   (input valid, input red_cathode, input green_cathode,
                  input anode, input scan_row, output ready);
endinterface

>>> rtl/core/bclm_store.sv
// ----------------------------------------------------------------------------
// bclm_store
// Green and red plane memories with registered read data and a
// per-row valid vector, so that a clear needs no pass over the rows.
// ----------------------------------------------------------------------------
module bclm_store #(
  parameter int ROWS = bclm_pkg::ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bclm_pkg::store_req_t   req,
  output bclm_pkg::store_rd_t    rd
);
  import bclm_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  plane_t            green_mem [ROWS];
  plane_t            red_mem   [ROWS];
  logic [ROWS-1:0]   vld_r;
  logic [ROWS-1:0]   vld_nxt;
  logic              rd_vld_r;
  plane_t            rd_green_r;
  plane_t            rd_red_r;

  // Rows never written since the last clear read as zero.
  always_comb begin
    vld_nxt = vld_r;
    if (req.clr) begin
      vld_nxt = '0;
    end else if (req.wr_en) begin
      vld_nxt[req.wr_addr[ROW_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr[ROW_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      green_mem[req.wr_addr[ROW_W-1:0]] <= req.wr_green;
      red_mem[req.wr_addr[ROW_W-1:0]]   <= req.wr_red;
    end
    if (req.rd_en) begin
      rd_green_r <= green_mem[req.rd_addr[ROW_W-1:0]];
      rd_red_r   <= red_mem[req.rd_addr[ROW_W-1:0]];
    end
  end

  assign rd.green = rd_vld_r ? rd_green_r : '0;
  assign rd.red   = rd_vld_r ? rd_red_r   : '0;

  // The sequencer never reads and writes in the same cycle.
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> !req.rd_en)
    else $error("frame store read and write in the same cycle");

  // A clear leaves no row marked as written.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    req.clr |=> (vld_r == '0))
    else $error("valid rows remain after a clear");

  // A write marks its row unless a clear wins.
  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en && !req.clr) |=> vld_r[$past(req.wr_addr[ROW_W-1:0])])
    else $error("written row not marked valid");

endmodule

>>> rtl/core/bicolor_led_matrix_scan_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// bicolor_led_matrix_scan_framebuffer_unit
// Bicolour LED matrix frame store with a row-scan latch word output.
// ----------------------------------------------------------------------------
// Usage: command beats arrive on in_ch (mode, color, pixel_row, pixel_bit).
// A plot beat sets or clears one pixel, a clear beat wipes both planes and
// returns the scan row to 0; neither produces an output beat. A scan beat
// produces one latch word on out_ch (inverted red row, inverted green row,
// one-hot anode and the row index) and advances the scan row modulo ROWS.
// A blank beat produces an all-zero word.
// in_ch is ready only in the idle state, so a command is not taken before
// the last one is done. On acceptance the row is read from the plane
// memories, whose read data is registered; the execute state then writes a
// plot back or loads the output register. out_ch.valid comes from the output
// register, so it rises at the edge that loads a scan or blank word.
// When the receiver stalls, the finished word waits in the output register.
// Plots and clears still pass, and the next scan or blank is accepted but
// holds in its execute state until the register frees, blocking in_ch.
// Reset clears the row-valid bits, the scan row and both handshakes at once,
// so the store reads as all zero with no clearing pass.
// ----------------------------------------------------------------------------
module bicolor_led_matrix_scan_framebuffer_unit #(
  parameter int ROWS = bclm_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bclm_in_if.sink     in_ch,
  bclm_out_if.source  out_ch
);
  import bclm_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_r, state_nxt;
  logic [ROW_W-1:0] scan_cnt_r, scan_cnt_nxt;
  mode_t            mode_r;
  color_t           color_r;
  row_t             wr_addr_r;
  bit_t             bit_r;
  logic             row_hit_r;

  logic             out_valid_r, out_valid_nxt;
  plane_t           out_red_r, out_green_r, out_anode_r;
  row_t             out_row_r;

  logic             in_accept;
  logic             out_free;
  logic             out_load;
  plane_t           mask;
  store_req_t       req;
  store_rd_t        rd;

  assign in_accept = in_ch.valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign mask      = TOP_BIT >> bit_r;

  // Sequencer: read on acceptance, then in the execute state modify and write back or emit.
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    out_load     = 1'b0;
    req          = '0;
    req.wr_addr  = wr_addr_r;
    req.wr_green = rd.green;
    req.wr_red   = rd.red;
    req.rd_addr  = (in_ch.mode == MODE_SCAN) ? row_t'(scan_cnt_r) : in_ch.pixel_row;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          req.rd_en = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      default: begin
        unique case (mode_r)
          MODE_PLOT: begin
            req.wr_en = row_hit_r;
            unique case (color_r)
              COLOR_OFF: begin
                req.wr_green = rd.green & ~mask;
                req.wr_red   = rd.red & ~mask;
              end
              COLOR_GREEN:  req.wr_green = rd.green | mask;
              COLOR_RED:    req.wr_red   = rd.red | mask;
              default: begin
                req.wr_green = rd.green | mask;
                req.wr_red   = rd.red | mask;
              end
            endcase
            state_nxt = ST_IDLE;
          end
          MODE_CLEAR: begin
            req.clr      = 1'b1;
            scan_cnt_nxt = '0;
            state_nxt    = ST_IDLE;
          end
          default: begin
            // Scan and blank wait here until the output register is free.
            if (out_free) begin
              out_load  = 1'b1;
              state_nxt = ST_IDLE;
              if (mode_r == MODE_SCAN) begin
                scan_cnt_nxt = (scan_cnt_r == ROW_W'(ROWS - 1)) ? '0
                                                                : scan_cnt_r + 1'b1;
              end
            end
          end
        endcase
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command fields held for the execute state.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r    <= in_ch.mode;
      color_r   <= in_ch.color;
      wr_addr_r <= in_ch.pixel_row;
      bit_r     <= in_ch.pixel_bit;
      row_hit_r <= ({1'b0, in_ch.pixel_row} < 5'(ROWS));
    end
  end

  // Output register; a blank word is zero in every field.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (mode_r == MODE_SCAN) begin
        out_red_r   <= ~rd.red;
        out_green_r <= ~rd.green;
        out_anode_r <= TOP_BIT >> scan_cnt_r;
        out_row_r   <= row_t'(scan_cnt_r);
      end else begin
        out_red_r   <= '0;
        out_green_r <= '0;
        out_anode_r <= '0;
        out_row_r   <= '0;
      end
    end
  end

  bclm_store #(
    .ROWS (ROWS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rd    (rd)
  );

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.red_cathode   = out_red_r;
  assign out_ch.green_cathode = out_green_r;
  assign out_ch.anode         = out_anode_r;
  assign out_ch.scan_row      = out_row_r;

  // The scan row never leaves the populated rows.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_cnt_r <= ROW_W'(ROWS - 1))
    else $error("scan row beyond the last row");

  // A clear always returns the scan row to the top.
  a_clear_resets_scan: assert property (@(posedge clk) disable iff (!rst_n)
    req.clr |=> (scan_cnt_r == '0))
    else $error("scan row not reset by a clear");

  // Plots and clears never produce a latch word.
  a_no_word_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && (mode_r == MODE_PLOT || mode_r == MODE_CLEAR))
      |-> !out_load)
    else $error("latch word produced by a plot or clear");

endmodule
